### design/hakm_pkg.sv
// shared types and constants of the hunt-and-kill maze carver
// no dependencies
`default_nettype none
package hakm_pkg;

  localparam int MAX_DIM = 64;
  localparam int DIM_W   = $clog2(MAX_DIM);
  localparam int ADDR_W  = 2 * DIM_W;

  typedef enum logic [1:0] {
    DIR_DOWN  = 2'd0,
    DIR_UP    = 2'd1,
    DIR_RIGHT = 2'd2,
    DIR_LEFT  = 2'd3
  } dir_e;

  typedef dir_e dir_ord_t [4];

  typedef enum logic [2:0] {
    EV_CLEARED  = 3'd0,
    EV_WALK     = 3'd1,
    EV_WALK_END = 3'd2,
    EV_SEED     = 3'd3,
    EV_FINISHED = 3'd4
  } event_e;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_WALK = 2'd1,
    PH_DONE = 2'd2
  } phase_e;

  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

endpackage
`default_nettype wire

### design/hakm_dir_order.sv
// orders the four directions from the three random picks of a step word
// depends on hakm_pkg
`default_nettype none
module hakm_dir_order (
  input  logic [1:0]        pick_first_i,
  input  logic [1:0]        pick_second_i,
  input  logic              pick_third_i,
  output hakm_pkg::dir_ord_t ord_o
);
  import hakm_pkg::*;

  always_comb begin
    dir_e       av [4];
    logic [1:0] p;
    av[0] = DIR_DOWN;
    av[1] = DIR_UP;
    av[2] = DIR_RIGHT;
    av[3] = DIR_LEFT;
    for (int k = 0; k < 4; k++) begin
      case (k)
        0:       p = pick_first_i;
        1:       p = (pick_second_i == 2'd3) ? 2'd2 : pick_second_i;
        2:       p = {1'b0, pick_third_i};
        default: p = 2'd0;
      endcase
      ord_o[k] = av[p];
      for (int j = 0; j < 3; j++) begin
        if (j >= int'(p)) begin
          av[j] = av[j+1];
        end
      end
    end
  end

endmodule
`default_nettype wire

### design/hunt_and_kill_maze_carver.sv
// hunt-and-kill maze carver: top level with the grid memory and sequencer
// depends on hakm_pkg and hakm_dir_order
`default_nettype none
// Carves a perfect maze into a 64 x 64 one-bit grid memory, one result word per input
// word. After reset, and for every restart word, the grid is cleared by a sweep of all
// 4096 cells, then the start cell is set; no word is taken meanwhile. A walk step tries
// the directions in turn: for each whose target lies in the grid it issues the address,
// then checks the read data; one whose target does not is skipped. Once a free target
// is carved, the wall between is written, then the output register is loaded. A hunt
// step scans the odd cells one memory read at a time. A result waits in an output
// register, so the next word is taken while it is still stalled.
module hunt_and_kill_maze_carver (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_index_i,
  input  logic [5:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       mode_i,
  input  logic [1:0] pick_first_i,
  input  logic [1:0] pick_second_i,
  input  logic       pick_third_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] event_res_o,
  output logic [5:0] cell_row_o,
  output logic [5:0] cell_col_o,
  output logic [5:0] wall_row_o,
  output logic [5:0] wall_col_o
);
  import hakm_pkg::*;

  typedef enum logic [10:0] {
    S_CLEAR = 11'b00000000001,
    S_SEED  = 11'b00000000010,
    S_IDLE  = 11'b00000000100,
    S_WREQ  = 11'b00000001000,
    S_WCHK  = 11'b00000010000,
    S_WMID  = 11'b00000100000,
    S_HCELL = 11'b00001000000,
    S_HCHK  = 11'b00010000000,
    S_HDIR  = 11'b00100000000,
    S_HDCHK = 11'b01000000000,
    S_PUSH  = 11'b10000000000
  } state_e;

  state_e            state_q, state_d;
  logic [5:0]        rows_q, cols_q;
  logic [DIM_W-1:0]  rows_eff, cols_eff;
  phase_e            phase_q, phase_d;
  logic [DIM_W-1:0]  walk_r_q, walk_r_d, walk_c_q, walk_c_d;
  logic [DIM_W:0]    scan_r_q, scan_r_d, scan_c_q, scan_c_d;
  logic [1:0]        k_q, k_d;
  dir_ord_t          ord_q, ord_d, ord_in;
  logic [ADDR_W-1:0] clr_q, clr_d, mid_q, mid_d;
  logic              clr_res_q, clr_res_d;
  event_e            res_ev_q, res_ev_d;
  logic [5:0]        res_cr_q, res_cr_d, res_cc_q, res_cc_d;
  logic [5:0]        res_wr_q, res_wr_d, res_wc_q, res_wc_d;
  logic              out_valid_q, out_valid_d;
  event_e            out_ev_q, out_ev_d;
  logic [5:0]        out_cr_q, out_cr_d, out_cc_q, out_cc_d;
  logic [5:0]        out_wr_q, out_wr_d, out_wc_q, out_wc_d;

  logic              mem_q [1<<ADDR_W];
  logic              we, wdata, re, rdata_q;
  logic [ADDR_W-1:0] waddr, raddr;

  logic              hunting;
  logic [DIM_W-1:0]  base_r, base_c;
  dir_e              cur_dir;
  logic signed [DIM_W+1:0] dr, dc, tr, tc, mr, mc;
  logic              tgt_ok;
  logic [ADDR_W-1:0] tgt_addr, mid_addr, scan_addr;

  hakm_dir_order u_order (
    .pick_first_i (pick_first_i),
    .pick_second_i(pick_second_i),
    .pick_third_i (pick_third_i),
    .ord_o        (ord_in)
  );

  assign rows_eff = (rows_q < 6'd3) ? DIM_W'(3) : DIM_W'(rows_q | 6'd1);
  assign cols_eff = (cols_q < 6'd3) ? DIM_W'(3) : DIM_W'(cols_q | 6'd1);

  assign hunting = (state_q == S_HDIR) || (state_q == S_HDCHK);
  assign base_r  = hunting ? scan_r_q[DIM_W-1:0] : walk_r_q;
  assign base_c  = hunting ? scan_c_q[DIM_W-1:0] : walk_c_q;
  assign cur_dir = ord_q[k_q];

  always_comb begin
    dr = '0;
    dc = '0;
    case (cur_dir)
      DIR_DOWN:  dr = (DIM_W+2)'(1);
      DIR_UP:    dr = -(DIM_W+2)'(1);
      DIR_RIGHT: dc = (DIM_W+2)'(1);
      DIR_LEFT:  dc = -(DIM_W+2)'(1);
      default:   dr = '0;
    endcase
  end

  assign tr = $signed({2'b00, base_r}) + (dr <<< 1);
  assign tc = $signed({2'b00, base_c}) + (dc <<< 1);
  assign mr = $signed({2'b00, base_r}) + dr;
  assign mc = $signed({2'b00, base_c}) + dc;
  assign tgt_ok = !tr[DIM_W+1] && (tr[DIM_W:0] < {1'b0, rows_eff})
               && !tc[DIM_W+1] && (tc[DIM_W:0] < {1'b0, cols_eff});
  assign tgt_addr  = {tr[DIM_W-1:0], tc[DIM_W-1:0]};
  assign mid_addr  = {mr[DIM_W-1:0], mc[DIM_W-1:0]};
  assign scan_addr = {scan_r_q[DIM_W-1:0], scan_c_q[DIM_W-1:0]};

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    walk_r_d    = walk_r_q;
    walk_c_d    = walk_c_q;
    scan_r_d    = scan_r_q;
    scan_c_d    = scan_c_q;
    k_d         = k_q;
    ord_d       = ord_q;
    clr_d       = clr_q;
    mid_d       = mid_q;
    clr_res_d   = clr_res_q;
    res_ev_d    = res_ev_q;
    res_cr_d    = res_cr_q;
    res_cc_d    = res_cc_q;
    res_wr_d    = res_wr_q;
    res_wc_d    = res_wc_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_ev_d    = out_ev_q;
    out_cr_d    = out_cr_q;
    out_cc_d    = out_cc_q;
    out_wr_d    = out_wr_q;
    out_wc_d    = out_wc_q;
    we          = 1'b0;
    waddr       = tgt_addr;
    wdata       = 1'b1;
    re          = 1'b0;
    raddr       = tgt_addr;
    in_stall_o  = (state_q != S_IDLE);

    case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = 1'b0;
        clr_d = clr_q + ADDR_W'(1);
        if (&clr_q) begin
          state_d = S_SEED;
        end
      end
      S_SEED: begin
        we       = 1'b1;
        waddr    = {DIM_W'(1), DIM_W'(1)};
        walk_r_d = '0;
        walk_c_d = '0;
        phase_d  = PH_HUNT;
        clr_res_d = 1'b0;
        if (clr_res_q) begin
          res_ev_d = EV_CLEARED;
          res_cr_d = 6'd1;
          res_cc_d = 6'd1;
          res_wr_d = '0;
          res_wc_d = '0;
          state_d  = S_PUSH;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          ord_d = ord_in;
          k_d   = '0;
          if (!mode_i) begin
            clr_res_d = 1'b1;
            clr_d     = '0;
            state_d   = S_CLEAR;
          end else begin
            case (phase_q)
              PH_WALK: state_d = S_WREQ;
              PH_HUNT: begin
                scan_r_d = (DIM_W+1)'(1);
                scan_c_d = (DIM_W+1)'(1);
                state_d  = S_HCELL;
              end
              default: begin
                res_ev_d = EV_FINISHED;
                res_cr_d = '0;
                res_cc_d = '0;
                res_wr_d = '0;
                res_wc_d = '0;
                state_d  = S_PUSH;
              end
            endcase
          end
        end
      end
      S_WREQ: begin
        if (tgt_ok) begin
          re      = 1'b1;
          state_d = S_WCHK;
        end else if (k_q == 2'd3) begin
          phase_d  = PH_HUNT;
          res_ev_d = EV_WALK_END;
          res_cr_d = '0;
          res_cc_d = '0;
          res_wr_d = '0;
          res_wc_d = '0;
          state_d  = S_PUSH;
        end else begin
          k_d = k_q + 2'd1;
        end
      end
      S_WCHK: begin
        if (!rdata_q) begin
          we       = 1'b1;
          mid_d    = mid_addr;
          walk_r_d = tr[DIM_W-1:0];
          walk_c_d = tc[DIM_W-1:0];
          res_ev_d = EV_WALK;
          res_cr_d = 6'(tr[DIM_W-1:0]);
          res_cc_d = 6'(tc[DIM_W-1:0]);
          res_wr_d = 6'(mr[DIM_W-1:0]);
          res_wc_d = 6'(mc[DIM_W-1:0]);
          state_d  = S_WMID;
        end else if (k_q == 2'd3) begin
          phase_d  = PH_HUNT;
          res_ev_d = EV_WALK_END;
          res_cr_d = '0;
          res_cc_d = '0;
          res_wr_d = '0;
          res_wc_d = '0;
          state_d  = S_PUSH;
        end else begin
          k_d     = k_q + 2'd1;
          state_d = S_WREQ;
        end
      end
      S_WMID: begin
        we      = 1'b1;
        waddr   = mid_q;
        state_d = S_PUSH;
      end
      S_HCELL: begin
        if (scan_r_q >= {1'b0, rows_eff}) begin
          phase_d  = PH_DONE;
          res_ev_d = EV_FINISHED;
          res_cr_d = '0;
          res_cc_d = '0;
          res_wr_d = '0;
          res_wc_d = '0;
          state_d  = S_PUSH;
        end else if (scan_c_q >= {1'b0, cols_eff}) begin
          scan_r_d = scan_r_q + (DIM_W+1)'(2);
          scan_c_d = (DIM_W+1)'(1);
        end else begin
          re      = 1'b1;
          raddr   = scan_addr;
          state_d = S_HCHK;
        end
      end
      S_HCHK: begin
        k_d = '0;
        if (rdata_q) begin
          scan_c_d = scan_c_q + (DIM_W+1)'(2);
          state_d  = S_HCELL;
        end else begin
          state_d = S_HDIR;
        end
      end
      S_HDIR: begin
        if (tgt_ok) begin
          re      = 1'b1;
          state_d = S_HDCHK;
        end else if (k_q == 2'd3) begin
          scan_c_d = scan_c_q + (DIM_W+1)'(2);
          state_d  = S_HCELL;
        end else begin
          k_d = k_q + 2'd1;
        end
      end
      S_HDCHK: begin
        if (rdata_q) begin
          we       = 1'b1;
          waddr    = scan_addr;
          mid_d    = mid_addr;
          walk_r_d = scan_r_q[DIM_W-1:0];
          walk_c_d = scan_c_q[DIM_W-1:0];
          phase_d  = PH_WALK;
          res_ev_d = EV_SEED;
          res_cr_d = 6'(scan_r_q[DIM_W-1:0]);
          res_cc_d = 6'(scan_c_q[DIM_W-1:0]);
          res_wr_d = 6'(mr[DIM_W-1:0]);
          res_wc_d = 6'(mc[DIM_W-1:0]);
          state_d  = S_WMID;
        end else if (k_q == 2'd3) begin
          scan_c_d = scan_c_q + (DIM_W+1)'(2);
          state_d  = S_HCELL;
        end else begin
          k_d     = k_q + 2'd1;
          state_d = S_HDIR;
        end
      end
      S_PUSH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_ev_d    = res_ev_q;
          out_cr_d    = res_cr_q;
          out_cc_d    = res_cc_q;
          out_wr_d    = res_wr_q;
          out_wc_d    = res_wc_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      rows_q      <= 6'd63;
      cols_q      <= 6'd63;
      phase_q     <= PH_HUNT;
      walk_r_q    <= '0;
      walk_c_q    <= '0;
      clr_q       <= '0;
      clr_res_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      walk_r_q    <= walk_r_d;
      walk_c_q    <= walk_c_d;
      clr_q       <= clr_d;
      clr_res_q   <= clr_res_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_ROWS) begin
          rows_q <= cfg_data_i;
        end else begin
          cols_q <= cfg_data_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    scan_r_q <= scan_r_d;
    scan_c_q <= scan_c_d;
    k_q      <= k_d;
    ord_q    <= ord_d;
    mid_q    <= mid_d;
    res_ev_q <= res_ev_d;
    res_cr_q <= res_cr_d;
    res_cc_q <= res_cc_d;
    res_wr_q <= res_wr_d;
    res_wc_q <= res_wc_d;
    out_ev_q <= out_ev_d;
    out_cr_q <= out_cr_d;
    out_cc_q <= out_cc_d;
    out_wr_q <= out_wr_d;
    out_wc_q <= out_wc_d;
  end

  assign out_valid_o = out_valid_q;
  assign event_res_o = out_ev_q;
  assign cell_row_o  = out_cr_q;
  assign cell_col_o  = out_cc_q;
  assign wall_row_o  = out_wr_q;
  assign wall_col_o  = out_wc_q;

  a_push_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_PUSH))
    else $error("result word loaded outside push state");

  a_walk_odd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_WALK) |-> (walk_r_q[0] && walk_c_q[0]))
    else $error("walk position is not an odd cell");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(we && re && (waddr == raddr)))
    else $error("grid read and write hit the same cell");

endmodule
`default_nettype wire
